### rtl/point_in_convex_polygon_fan_assert.svh
// ----------------------------------------------------------------------------
// point_in_convex_polygon_fan assertion macros
// short property forms shared by the checker
// ----------------------------------------------------------------------------
`ifndef POINT_IN_CONVEX_POLYGON_FAN_ASSERT_SVH
`define POINT_IN_CONVEX_POLYGON_FAN_ASSERT_SVH

// same-cycle implication
`define PICPF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("point_in_convex_polygon_fan: same-cycle check failed");

// next-cycle implication
`define PICPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("point_in_convex_polygon_fan: next-cycle check failed");

`endif

### rtl/picpf_pkg.sv
// ----------------------------------------------------------------------------
// picpf_pkg
// vertex count type and codes for the triangle fan point test
// ----------------------------------------------------------------------------
package picpf_pkg;

  typedef logic [1:0] vcount_t;

  localparam vcount_t CountNone  = 2'd0;
  localparam vcount_t CountOne   = 2'd1;
  localparam vcount_t CountTwo   = 2'd2;
  localparam vcount_t CountThree = 2'd3;

endpackage

### rtl/point_in_convex_polygon_fan.sv
// ----------------------------------------------------------------------------
// point_in_convex_polygon_fan
// streamed point-in-convex-polygon test over a triangle fan from vertex one
// ----------------------------------------------------------------------------
// One vertex word is accepted per clock while stall_o is low; its result, if
// it is the last vertex of a polygon, is loaded into the output register
// when that word leaves the input register. The rate is set by the
// combinational triangle test: six exact products of (COORD_WIDTH+1)-bit
// differences and three cross-product signs sit between the input register
// and the state and result registers. stall_o rises only when a last vertex
// waits in the input register while a result still sits unaccepted in the
// output register.
module point_in_convex_polygon_fan
  import picpf_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic signed [COORD_WIDTH-1:0] query_x_i,
  input  logic signed [COORD_WIDTH-1:0] query_y_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_y_i,
  input  logic                          last_vertex_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic                          inside_res_o,
  output logic                          too_few_vertices_o
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int XW = PW + 1;

  // input register
  logic                          in_valid_q;
  logic signed [COORD_WIDTH-1:0] in_qx_q, in_qy_q, in_vx_q, in_vy_q;
  logic                          in_last_q;

  // polygon state
  logic signed [COORD_WIDTH-1:0] hqx_q, hqy_q, ax_q, ay_q, bx_q, by_q;
  vcount_t                       cnt_q;
  logic                          hit_q;

  // result register
  logic out_valid_q, out_inside_q, out_few_q;

  logic in_take, in_adv, out_load;

  logic signed [COORD_WIDTH-1:0] qx, qy;
  logic signed [DW-1:0] d_ax_px, d_by_ay, d_bx_ax, d_ay_py;
  logic signed [DW-1:0] d_bx_px, d_cy_by, d_cx_bx, d_by_py;
  logic signed [DW-1:0] d_cx_px, d_ay_cy, d_ax_cx, d_cy_py;
  logic signed [PW-1:0] p1a, p1b, p2a, p2b, p3a, p3b;
  logic signed [XW-1:0] x1, x2, x3;
  logic n1, n2, n3, z1, z2, z3;
  logic tri_hit, few;

  function automatic logic signed [DW-1:0] sub_ext(
    input logic signed [COORD_WIDTH-1:0] a,
    input logic signed [COORD_WIDTH-1:0] b
  );
    logic signed [DW-1:0] ae, be;
    ae = {a[COORD_WIDTH-1], a};
    be = {b[COORD_WIDTH-1], b};
    return ae - be;
  endfunction

  assign stall_o  = in_valid_q && in_last_q && out_valid_q && stall_i;
  assign in_take  = valid_i && !stall_o;
  assign in_adv   = in_valid_q && !stall_o;
  assign out_load = in_adv && in_last_q;

  // query comes from the first vertex of a polygon
  assign qx = (cnt_q == CountNone) ? in_qx_q : hqx_q;
  assign qy = (cnt_q == CountNone) ? in_qy_q : hqy_q;

  // a = anchor, b = previous, c = current vertex
  assign d_ax_px = sub_ext(ax_q, qx);
  assign d_by_ay = sub_ext(by_q, ay_q);
  assign d_bx_ax = sub_ext(bx_q, ax_q);
  assign d_ay_py = sub_ext(ay_q, qy);
  assign d_bx_px = sub_ext(bx_q, qx);
  assign d_cy_by = sub_ext(in_vy_q, by_q);
  assign d_cx_bx = sub_ext(in_vx_q, bx_q);
  assign d_by_py = sub_ext(by_q, qy);
  assign d_cx_px = sub_ext(in_vx_q, qx);
  assign d_ay_cy = sub_ext(ay_q, in_vy_q);
  assign d_ax_cx = sub_ext(ax_q, in_vx_q);
  assign d_cy_py = sub_ext(in_vy_q, qy);

  assign p1a = PW'(d_ax_px) * PW'(d_by_ay);
  assign p1b = PW'(d_bx_ax) * PW'(d_ay_py);
  assign p2a = PW'(d_bx_px) * PW'(d_cy_by);
  assign p2b = PW'(d_cx_bx) * PW'(d_by_py);
  assign p3a = PW'(d_cx_px) * PW'(d_ay_cy);
  assign p3b = PW'(d_ax_cx) * PW'(d_cy_py);

  assign x1 = {p1a[PW-1], p1a} - {p1b[PW-1], p1b};
  assign x2 = {p2a[PW-1], p2a} - {p2b[PW-1], p2b};
  assign x3 = {p3a[PW-1], p3a} - {p3b[PW-1], p3b};

  assign n1 = x1[XW-1];
  assign n2 = x2[XW-1];
  assign n3 = x3[XW-1];
  assign z1 = (x1 == '0);
  assign z2 = (x2 == '0);
  assign z3 = (x3 == '0);

  assign tri_hit = (!n1 && !n2 && !n3) || ((n1 || z1) && (n2 || z2) && (n3 || z3));

  // fewer than three once this vertex is counted
  assign few = (cnt_q == CountNone) || (cnt_q == CountOne);

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (in_adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_qx_q   <= query_x_i;
      in_qy_q   <= query_y_i;
      in_vx_q   <= vertex_x_i;
      in_vy_q   <= vertex_y_i;
      in_last_q <= last_vertex_i;
    end
  end

  // polygon state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hqx_q <= '0;
      hqy_q <= '0;
      ax_q  <= '0;
      ay_q  <= '0;
      bx_q  <= '0;
      by_q  <= '0;
      cnt_q <= CountNone;
      hit_q <= 1'b0;
    end else if (in_adv) begin
      case (cnt_q)
        CountNone: begin
          hqx_q <= in_qx_q;
          hqy_q <= in_qy_q;
          ax_q  <= in_vx_q;
          ay_q  <= in_vy_q;
          cnt_q <= in_last_q ? CountNone : CountOne;
          hit_q <= 1'b0;
        end
        CountOne: begin
          bx_q  <= in_vx_q;
          by_q  <= in_vy_q;
          cnt_q <= in_last_q ? CountNone : CountTwo;
        end
        default: begin
          bx_q  <= in_vx_q;
          by_q  <= in_vy_q;
          cnt_q <= in_last_q ? CountNone : CountThree;
          hit_q <= !in_last_q && (hit_q || tri_hit);
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_few_q    <= few;
      out_inside_q <= !few && (hit_q || tri_hit);
    end
  end

  assign valid_o            = out_valid_q;
  assign inside_res_o       = out_inside_q;
  assign too_few_vertices_o = out_few_q;

endmodule

### rtl/picpf_checker.sv
// ----------------------------------------------------------------------------
// picpf_checker
// port-level checks for point_in_convex_polygon_fan, bound to the top level
// ----------------------------------------------------------------------------
`include "point_in_convex_polygon_fan_assert.svh"

module picpf_checker #(
  parameter int COORD_WIDTH = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          valid_i,
  input logic                          stall_o,
  input logic signed [COORD_WIDTH-1:0] query_x_i,
  input logic signed [COORD_WIDTH-1:0] query_y_i,
  input logic signed [COORD_WIDTH-1:0] vertex_x_i,
  input logic signed [COORD_WIDTH-1:0] vertex_y_i,
  input logic                          last_vertex_i,
  input logic                          valid_o,
  input logic                          stall_i,
  input logic                          inside_res_o,
  input logic                          too_few_vertices_o
);

  logic       last_in, word_out;
  logic [1:0] pend_q;
  logic       coord_any;
  logic [1:0] res_w;

  assign last_in   = valid_i && !stall_o && last_vertex_i;
  assign word_out  = valid_o && !stall_i;
  assign coord_any = ^{query_x_i, query_y_i, vertex_x_i, vertex_y_i};
  assign res_w     = {inside_res_o, too_few_vertices_o};

  // last vertices taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else if (last_in && !word_out) begin
      pend_q <= pend_q + 2'd1;
    end else if (word_out && !last_in) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  `PICPF_ASSERT_NEXT(a_out_hold, valid_o && stall_i, valid_o && $stable(res_w))
  `PICPF_ASSERT_NOW(a_res_excl, valid_o, !(inside_res_o && too_few_vertices_o))
  `PICPF_ASSERT_NOW(a_no_stall_empty, !valid_o, !stall_o || (coord_any && !coord_any))
  `PICPF_ASSERT_NOW(a_pend_bound, 1'b1, (pend_q != 2'd3) && (!valid_o || pend_q != 2'd0))

endmodule

bind point_in_convex_polygon_fan picpf_checker #(.COORD_WIDTH(COORD_WIDTH)) u_checker (.*);

### bench/polygon_hit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_hit_checker
// watches the vertex and result channels of the triangle fan point test,
// predicts each polygon verdict from the accepted vertex words and compares
// every accepted result word against the oldest prediction
// ----------------------------------------------------------------------------
module polygon_hit_checker
  import picpf_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic signed [COORD_WIDTH-1:0] query_x_i,
  input  logic signed [COORD_WIDTH-1:0] query_y_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_y_i,
  input  logic                          last_vertex_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic                          inside_res_i,
  input  logic                          too_few_vertices_i,
  output int                            error_count_o,
  output int                            pending_o
);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic hit;
    logic too_few;
  } verdict_t;

  verdict_t verdict_q[$];
  verdict_t verdict;
  coord_t   held_qx, held_qy, anchor_x, anchor_y, prev_x, prev_y;
  vcount_t  seen;
  logic     fan_hit;
  int       errors;

  function automatic int cross_sign(longint a, longint b, longint c, longint d);
    longint p;
    p = a * b - c * d;
    if (p < 0) return -1;
    return (p == 0) ? 0 : 1;
  endfunction

  function automatic logic fan_triangle_hit(longint px, longint py, longint ax, longint ay,
                                            longint bx, longint by, longint cx, longint cy);
    int s1, s2, s3;
    s1 = cross_sign(ax - px, by - ay, bx - ax, ay - py);
    s2 = cross_sign(bx - px, cy - by, cx - bx, by - py);
    s3 = cross_sign(cx - px, ay - cy, ax - cx, cy - py);
    return (s1 >= 0 && s2 >= 0 && s3 >= 0) || (s1 <= 0 && s2 <= 0 && s3 <= 0);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_qx = '0;
      held_qy = '0;
      anchor_x = '0;
      anchor_y = '0;
      prev_x = '0;
      prev_y = '0;
      seen = CountNone;
      fan_hit = 1'b0;
      errors = 0;
      verdict_q.delete();
      error_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, inside_res %0b too_few_vertices %0b",
                   $time, inside_res_i, too_few_vertices_i);
        end else begin
          verdict = verdict_q.pop_front();
          if (inside_res_i !== verdict.hit) begin
            errors++;
            $display("%0t: inside_res expected %0b actual %0b",
                     $time, verdict.hit, inside_res_i);
          end
          if (too_few_vertices_i !== verdict.too_few) begin
            errors++;
            $display("%0t: too_few_vertices expected %0b actual %0b",
                     $time, verdict.too_few, too_few_vertices_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (seen)
          CountNone: begin
            held_qx = query_x_i;
            held_qy = query_y_i;
            anchor_x = vertex_x_i;
            anchor_y = vertex_y_i;
            fan_hit = 1'b0;
            seen = CountOne;
          end
          CountOne: begin
            prev_x = vertex_x_i;
            prev_y = vertex_y_i;
            seen = CountTwo;
          end
          default: begin
            if (fan_triangle_hit(held_qx, held_qy, anchor_x, anchor_y,
                                 prev_x, prev_y, vertex_x_i, vertex_y_i)) begin
              fan_hit = 1'b1;
            end
            prev_x = vertex_x_i;
            prev_y = vertex_y_i;
            seen = CountThree;
          end
        endcase
        if (last_vertex_i) begin
          verdict.too_few = (seen != CountThree);
          verdict.hit = (seen == CountThree) && fan_hit;
          verdict_q.push_back(verdict);
          seen = CountNone;
          fan_hit = 1'b0;
        end
      end
      error_count_o <= errors;
      pending_o <= verdict_q.size();
    end
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives polygons vertex by vertex into the triangle fan point test: a short
// directed set of corner cases, then mostly random convex polygons around
// random centers with queries near and on them, mixed with random noise
// polygons; both channels idle and stall at random, verdict from the checker
// ----------------------------------------------------------------------------
module testbench;
  import picpf_pkg::*;

  localparam int CoordWidth  = 16;
  localparam int ItemTarget  = 1700;
  localparam int IdleLimit   = 1000;
  localparam int DrainCycles = 10;

  typedef logic signed [CoordWidth-1:0] coord_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   valid_i = 1'b0;
  logic   stall_i = 1'b0;
  coord_t query_x_i = '0;
  coord_t query_y_i = '0;
  coord_t vertex_x_i = '0;
  coord_t vertex_y_i = '0;
  logic   last_vertex_i = 1'b0;
  logic   stall_o, valid_o, inside_res_o, too_few_vertices_o;

  int error_count, pending;
  int items_sent = 0;
  int polygons_sent = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  point_in_convex_polygon_fan #(
    .COORD_WIDTH(CoordWidth)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (valid_i),
    .stall_o           (stall_o),
    .query_x_i         (query_x_i),
    .query_y_i         (query_y_i),
    .vertex_x_i        (vertex_x_i),
    .vertex_y_i        (vertex_y_i),
    .last_vertex_i     (last_vertex_i),
    .valid_o           (valid_o),
    .stall_i           (stall_i),
    .inside_res_o      (inside_res_o),
    .too_few_vertices_o(too_few_vertices_o)
  );

  polygon_hit_checker #(
    .COORD_WIDTH(CoordWidth)
  ) result_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (valid_i),
    .in_stall_i        (stall_o),
    .query_x_i         (query_x_i),
    .query_y_i         (query_y_i),
    .vertex_x_i        (vertex_x_i),
    .vertex_y_i        (vertex_y_i),
    .last_vertex_i     (last_vertex_i),
    .out_valid_i       (valid_o),
    .out_stall_i       (stall_i),
    .inside_res_i      (inside_res_o),
    .too_few_vertices_i(too_few_vertices_o),
    .error_count_o     (error_count),
    .pending_o         (pending)
  );

  // result side: hold off a random number of cycles after each accepted word
  always @(posedge clk_i or negedge rst_ni) begin
    int wait_cycles;
    if (!rst_ni) begin
      stall_i <= 1'b0;
      stall_left <= 0;
    end else if (valid_o && !stall_i) begin
      wait_cycles = rx_quiet ? 0 : $urandom_range(0, 15);
      stall_left <= wait_cycles;
      stall_i <= (wait_cycles != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_word(coord_t qx, coord_t qy, coord_t vx, coord_t vy, logic last);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    query_x_i <= qx;
    query_y_i <= qy;
    vertex_x_i <= vx;
    vertex_y_i <= vy;
    last_vertex_i <= last;
    valid_i <= 1'b1;
    do @(posedge clk_i); while (stall_o);
    items_sent++;
  endtask

  // later vertices carry a random query, which the block must ignore
  task automatic send_vertex(coord_t vx, coord_t vy, logic last);
    send_word(coord_t'($urandom), coord_t'($urandom), vx, vy, last);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0:       return coord_t'(16'sh8000);
      1:       return coord_t'(16'sh7fff);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // cosine of k * 45 degrees, scaled by 1000
  function automatic int dir_cos(int k);
    case (k % 8)
      0:       return 1000;
      1, 7:    return 707;
      3, 5:    return -707;
      4:       return -1000;
      default: return 0;
    endcase
  endfunction

  task automatic send_noise_polygon();
    int n;
    n = $urandom_range(1, 6);
    for (int j = 0; j < n; j++) begin
      send_word(rand_coord(), rand_coord(), rand_coord(), rand_coord(), j == n - 1);
    end
  endtask

  task automatic send_convex_polygon();
    int sel[$];
    int vxs[8];
    int vys[8];
    int cx, cy, r, rot, d, span, qx, qy, n;
    bit reverse;
    r = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 16000);
    cx = $urandom_range(0, 24000) - 12000;
    cy = $urandom_range(0, 24000) - 12000;
    rot = $urandom_range(0, 7);
    reverse = $urandom_range(0, 1);
    for (int k = 0; k < 8; k++) begin
      if ($urandom_range(0, 1)) sel.push_back(k);
    end
    if (sel.size() < 3) begin
      sel.delete();
      for (int k = 0; k < 8; k++) sel.push_back(k);
    end
    n = sel.size();
    for (int j = 0; j < n; j++) begin
      d = reverse ? (rot - sel[j] + 8) % 8 : (rot + sel[j]) % 8;
      vxs[j] = cx + dir_cos(d) * r / 1000;
      vys[j] = cy + dir_cos(d + 6) * r / 1000;
    end
    span = r + r / 4 + 1;
    case ($urandom_range(0, 5))
      0: begin
        qx = vxs[$urandom_range(0, n - 1)];
        qy = vys[0];
        if ($urandom_range(0, 1)) qy = vys[$urandom_range(0, n - 1)];
      end
      1: begin
        qx = cx;
        qy = cy;
      end
      default: begin
        qx = cx + $urandom_range(0, 2 * span) - span;
        qy = cy + $urandom_range(0, 2 * span) - span;
      end
    endcase
    send_word(coord_t'(qx), coord_t'(qy), coord_t'(vxs[0]), coord_t'(vys[0]), 1'b0);
    for (int j = 1; j < n; j++) begin
      send_vertex(coord_t'(vxs[j]), coord_t'(vys[j]), j == n - 1);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single vertex with extreme query and vertex
    send_word(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 1'b1);
    // two vertices
    send_word(16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd100, 16'sd100, 1'b1);
    // triangle, point inside
    send_word(16'sd100, 16'sd100, 16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd1000, 16'sd0, 1'b0);
    send_vertex(16'sd0, 16'sd1000, 1'b1);
    // triangle, point outside
    send_word(16'sd1000, 16'sd1000, 16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd1000, 16'sd0, 1'b0);
    send_vertex(16'sd0, 16'sd1000, 1'b1);
    // point on an edge
    send_word(16'sd500, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd1000, 16'sd0, 1'b0);
    send_vertex(16'sd0, 16'sd1000, 1'b1);
    // collinear vertices
    send_word(16'sd100, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd10, 16'sd10, 1'b0);
    send_vertex(16'sd20, 16'sd20, 1'b1);
    // full-range triangle
    send_word(16'sd0, -16'sd1, -16'sd32768, -16'sd32768, 1'b0);
    send_vertex(16'sd32767, -16'sd32768, 1'b0);
    send_vertex(16'sd32767, 16'sd32767, 1'b1);
    // square, point only in the second fan triangle
    send_word(16'sd2, 16'sd8, 16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd10, 16'sd0, 1'b0);
    send_vertex(16'sd10, 16'sd10, 1'b0);
    send_vertex(16'sd0, 16'sd10, 1'b1);

    while (items_sent < ItemTarget) begin
      if (polygons_sent % 40 == 0) begin
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet <= ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 4) == 0) begin
        send_noise_polygon();
      end else begin
        send_convex_polygon();
      end
      polygons_sent++;
    end
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
